// ===== hdl/smmm_pkg.sv =====
// Shared constants for the small-M matrix multiply block.
// Field widths, register indexes and default sizes.
// No dependencies.
package smmm_pkg;

   // default sizes handed to the top level
   localparam int DEF_MAX_ROWS   = 8;
   localparam int DEF_MAX_DEPTH  = 4096;
   localparam int DEF_VALUE_BITS = 16;

   // fixed field widths
   localparam int ROW_BITS      = 3;
   localparam int DIDX_BITS     = 12;
   localparam int COL_BITS      = 16;
   localparam int ACC_BITS      = 48;
   localparam int ROWS_CNT_BITS = 5;   // holds an effective row count up to 16
   localparam int DCNT_BITS     = 17;  // holds an effective depth up to 65536

   // register widths
   localparam int CFG_ROWS_BITS  = 4;
   localparam int CFG_DEPTH_BITS = 13;
   localparam int CFG_COLS_BITS  = 16;

   // configuration port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROWS  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEPTH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COLS  = 2'd2;

   // item kinds carried on req_tuser
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_RHS  = 1'b1;

   // result beat layout: out_row, out_column, sum, zero fill
   localparam int RSP_FIELD_BITS = ROW_BITS + COL_BITS + ACC_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - RSP_FIELD_BITS;

endpackage

// ===== hdl/smmm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered. No package needed.
module smmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/small_m_matrix_multiply.sv =====
// Small-M matrix multiply top level: lhs store, row accumulators, result stream.
// Depends on smmm_pkg and smmm_ram.
//
//  channel | direction | handshake             | beat contents
//  --------+-----------+-----------------------+-------------------------------------------
//  req     | in        | req_tvalid/req_tready | tuser kind; tdata row, depth_index, value
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata out_row, out_column, sum; tlast last
//  csr     | in        | csr_valid/csr_ready   | csr_index register, csr_data value
//
// A load beat reads the lhs word of all rows, merges the element in and writes it back.
// An rhs beat runs an lhs word read, one multiplier per row, then an accumulate.
// The beat that ends a column then emits one result beat per active row, held
// back while rsp_tready is low; the output register lets the next req beat in
// while the last result of a column waits. Reset is synchronous and active high;
// the lhs store holds no reset state and needs no clearing pass.
module small_m_matrix_multiply
   import smmm_pkg::*;
#(
   parameter int MAX_ROWS   = DEF_MAX_ROWS,
   parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   localparam int REQ_DATA_BITS = ((ROW_BITS + DIDX_BITS + VALUE_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   // input stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // row, depth_index, value, zero fill
   input  logic                     req_tuser,   // kind
   // result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // out_row, out_column, sum, zero fill
   output logic                     rsp_tlast,
   // register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int DPOS_W   = $clog2(MAX_DEPTH);
   localparam int ROWIX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int LANE_W   = MAX_ROWS * VALUE_BITS;
   localparam int PROD_W   = 2 * VALUE_BITS;
   localparam int VAL_LSB  = ROW_BITS + DIDX_BITS;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_LOAD = 5'b00010,
      S_MUL  = 5'b00100,
      S_ACC  = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   // input beat fields
   logic [ROW_BITS-1:0]         req_row;
   logic [DIDX_BITS-1:0]        req_depth_index;
   logic signed [VALUE_BITS-1:0] req_value;
   logic                        req_fire;

   assign req_row         = req_tdata[ROW_BITS-1:0];
   assign req_depth_index = req_tdata[ROW_BITS +: DIDX_BITS];
   assign req_value       = req_tdata[VAL_LSB +: VALUE_BITS];
   assign req_fire        = req_tvalid && req_tready;

   // registers
   state_type                    state_ff, state_in;
   logic [CFG_ROWS_BITS-1:0]     cfg_rows_ff;
   logic [CFG_DEPTH_BITS-1:0]    cfg_depth_ff;
   logic [CFG_COLS_BITS-1:0]     cfg_cols_ff;
   logic [DPOS_W-1:0]            dpos_ff, dpos_in;
   logic [COL_BITS-1:0]          col_ff, col_in;
   logic [ROWIX_W-1:0]           emit_row_ff, emit_row_in;
   logic signed [VALUE_BITS-1:0] val_ff;
   logic [ROWIX_W-1:0]           load_row_ff;
   logic [DPOS_W-1:0]            load_addr_ff;
   logic signed [PROD_W-1:0]     prod_ff [MAX_ROWS];
   logic signed [PROD_W-1:0]     prod_in [MAX_ROWS];
   logic [ACC_BITS-1:0]          acc_ff [MAX_ROWS];
   logic [ACC_BITS-1:0]          acc_in [MAX_ROWS];
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ROW_BITS-1:0]          rsp_row_ff;
   logic [COL_BITS-1:0]          rsp_col_ff;
   logic [ACC_BITS-1:0]          rsp_sum_ff;
   logic                         rsp_last_ff;

   // effective register values
   logic [ROWS_CNT_BITS-1:0] rows_eff;
   logic [DCNT_BITS-1:0]     depth_eff;
   logic [COL_BITS-1:0]      cols_eff;

   always_comb begin
      if (cfg_rows_ff == '0) begin
         rows_eff = ROWS_CNT_BITS'(1);
      end else if (ROWS_CNT_BITS'(cfg_rows_ff) > ROWS_CNT_BITS'(MAX_ROWS)) begin
         rows_eff = ROWS_CNT_BITS'(MAX_ROWS);
      end else begin
         rows_eff = ROWS_CNT_BITS'(cfg_rows_ff);
      end
      if (cfg_depth_ff == '0) begin
         depth_eff = DCNT_BITS'(1);
      end else if (DCNT_BITS'(cfg_depth_ff) > DCNT_BITS'(MAX_DEPTH)) begin
         depth_eff = DCNT_BITS'(MAX_DEPTH);
      end else begin
         depth_eff = DCNT_BITS'(cfg_depth_ff);
      end
      cols_eff = (cfg_cols_ff == '0) ? COL_BITS'(1) : cfg_cols_ff;
   end

   // register writes, always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_rows_ff  <= CFG_ROWS_BITS'(1);
         cfg_depth_ff <= CFG_DEPTH_BITS'(1);
         cfg_cols_ff  <= CFG_COLS_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROWS:  cfg_rows_ff  <= csr_data[CFG_ROWS_BITS-1:0];
            CSR_DEPTH: cfg_depth_ff <= csr_data[CFG_DEPTH_BITS-1:0];
            CSR_COLS:  cfg_cols_ff  <= csr_data[CFG_COLS_BITS-1:0];
            default:   ;
         endcase
      end
   end

   // lhs store: one word per depth, one lane per row
   logic              ram_we;
   logic [LANE_W-1:0] ram_wdata;
   logic              ram_re;
   logic [DPOS_W-1:0] ram_raddr;
   logic [LANE_W-1:0] ram_rdata;
   logic              load_ok;

   assign load_ok = (32'(req_row) < MAX_ROWS) && (32'(req_depth_index) < MAX_DEPTH);
   assign ram_re  = req_fire;
   assign ram_raddr = (req_tuser == KIND_LOAD) ? DPOS_W'(req_depth_index) : dpos_ff;
   assign ram_we  = (state_ff == S_LOAD);

   // merge the loaded element into its row lane
   always_comb begin
      ram_wdata = ram_rdata;
      ram_wdata[load_row_ff*VALUE_BITS +: VALUE_BITS] = val_ff;
   end

   smmm_ram #(
      .WIDTH (LANE_W),
      .DEPTH (MAX_DEPTH)
   ) u_lhs_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (load_addr_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // one multiplier per row lane
   always_comb begin
      for (int r = 0; r < MAX_ROWS; r++) begin
         prod_in[r] = $signed(ram_rdata[r*VALUE_BITS +: VALUE_BITS]) * val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         for (int r = 0; r < MAX_ROWS; r++) begin
            prod_ff[r] <= prod_in[r];
         end
      end
   end

   // position and emit bookkeeping
   logic [DCNT_BITS-1:0]     dpos_succ;
   logic [COL_BITS:0]        col_succ;
   logic                     rsp_load;
   logic                     emit_last;

   assign dpos_succ = DCNT_BITS'(dpos_ff) + DCNT_BITS'(1);
   assign col_succ  = (COL_BITS+1)'(col_ff) + (COL_BITS+1)'(1);
   assign rsp_load  = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign emit_last = (ROWS_CNT_BITS'(emit_row_ff) + ROWS_CNT_BITS'(1)) == rows_eff;

   // control sequencer and accumulators
   always_comb begin
      state_in     = state_ff;
      dpos_in      = dpos_ff;
      col_in       = col_ff;
      emit_row_in  = emit_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      for (int r = 0; r < MAX_ROWS; r++) begin
         acc_in[r] = acc_ff[r];
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser == KIND_RHS) begin
                  state_in = S_MUL;
               end else if (load_ok) begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            state_in = S_IDLE;
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            for (int r = 0; r < MAX_ROWS; r++) begin
               if (r < int'(rows_eff)) begin
                  acc_in[r] = acc_ff[r] + ACC_BITS'(prod_ff[r]);
               end
            end
            if (dpos_succ < depth_eff) begin
               dpos_in  = dpos_ff + DPOS_W'(1);
               state_in = S_IDLE;
            end else begin
               dpos_in     = '0;
               emit_row_in = '0;
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               emit_row_in  = emit_row_ff + ROWIX_W'(1);
               if (emit_last) begin
                  for (int r = 0; r < MAX_ROWS; r++) begin
                     acc_in[r] = '0;
                  end
                  col_in   = (col_succ >= (COL_BITS+1)'(cols_eff)) ? '0 : col_succ[COL_BITS-1:0];
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dpos_ff      <= '0;
         col_ff       <= '0;
         emit_row_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < MAX_ROWS; r++) begin
            acc_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         dpos_ff      <= dpos_in;
         col_ff       <= col_in;
         emit_row_ff  <= emit_row_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int r = 0; r < MAX_ROWS; r++) begin
            acc_ff[r] <= acc_in[r];
         end
      end
   end

   // input beat payload capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         val_ff       <= req_value;
         load_row_ff  <= ROWIX_W'(req_row);
         load_addr_ff <= DPOS_W'(req_depth_index);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_row_ff  <= ROW_BITS'(emit_row_ff);
         rsp_col_ff  <= col_ff;
         rsp_sum_ff  <= acc_ff[emit_row_ff];
         rsp_last_ff <= emit_last;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, rsp_sum_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks

   // an accepted rhs beat passes through the multiply state and then the accumulate state
   a_rhs_sequence: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == KIND_RHS |=> state_ff == S_MUL ##1 state_ff == S_ACC)
      else $error("rhs beat did not pass through multiply and accumulate");

   // the accumulators are cleared once the last result of a column is loaded
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_load && emit_last |=> acc_ff[0] == '0)
      else $error("accumulators not cleared after column end");

   // the column position only moves at the end of a result burst
   a_col_moves: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && col_ff != $past(col_ff) |-> $past(state_ff) == S_EMIT)
      else $error("column position changed outside result emission");

endmodule

// ===== verif/tb_small_m_matrix_multiply.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for small_m_matrix_multiply: directed script, then random phases.
// Predicts every dot product beat in-bench; depends on smmm_pkg and the block itself.
module tb_small_m_matrix_multiply;
   import smmm_pkg::*;

   localparam int VBITS         = DEF_VALUE_BITS;
   localparam int REQ_FIELDS    = ROW_BITS + DIDX_BITS + VBITS;
   localparam int REQ_BITS      = ((REQ_FIELDS + 7) / 8) * 8;
   localparam int REQ_PAD       = REQ_BITS - REQ_FIELDS;
   localparam int SETTLE_CYCLES = 16;      // covers the rhs pipeline after the last beat
   localparam int DRAIN_LIMIT   = 20000;
   localparam int LONG_HOLD     = 300;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 50;
   localparam int DEEP_ITEMS    = 12;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;   // no register behind it

   typedef enum logic [1:0] {STEP_LOAD, STEP_RHS, STEP_CSR} step_kind_type;

   typedef struct packed {
      logic                          kind;
      logic [ROW_BITS-1:0]           row;
      logic [DIDX_BITS-1:0]          didx;
      logic signed [VBITS-1:0]       value;
   } element_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]           row;
      logic [COL_BITS-1:0]           col;
      logic signed [ACC_BITS-1:0]    sum;
      logic                          last;
   } dot_type;

   // value doubles as csr data on register steps; known marks a hand-computed sum
   typedef struct packed {
      step_kind_type                 op;
      logic [CSR_IDX_BITS-1:0]       idx;
      logic [ROW_BITS-1:0]           row;
      logic [DIDX_BITS-1:0]          didx;
      logic signed [VBITS-1:0]       value;
      logic                          known;
      logic signed [ACC_BITS-1:0]    sum;
   } step_type;

   localparam int SCRIPT_LEN = 18;
   localparam step_type SCRIPT [SCRIPT_LEN] = '{
      // reset sizes: one row, depth 1, one column
      '{STEP_LOAD, CSR_ROWS,  3'd0, 12'd0,    16'sh7FFF, 1'b0, 48'sd0},
      '{STEP_RHS,  CSR_ROWS,  3'd0, 12'd0,    16'sh7FFF, 1'b1, 48'sd1073676289},
      '{STEP_LOAD, CSR_ROWS,  3'd0, 12'd0,    16'sh8000, 1'b0, 48'sd0},
      '{STEP_RHS,  CSR_ROWS,  3'd0, 12'd0,    16'sh8000, 1'b1, 48'sd1073741824},
      '{STEP_RHS,  CSR_ROWS,  3'd0, 12'd0,    16'sh7FFF, 1'b1, -48'sd1073709056},
      '{STEP_LOAD, CSR_ROWS,  3'd7, 12'd4095, 16'sh7FFF, 1'b0, 48'sd0},
      '{STEP_LOAD, CSR_ROWS,  3'd0, 12'd4095, 16'shFFFF, 1'b0, 48'sd0},
      // write to an unused index, then a row count of zero (acts as one)
      '{STEP_CSR,  CSR_SPARE, 3'd0, 12'd0,    16'shFFFF, 1'b0, 48'sd0},
      '{STEP_CSR,  CSR_ROWS,  3'd0, 12'd0,    16'shFFF0, 1'b0, 48'sd0},
      '{STEP_CSR,  CSR_DEPTH, 3'd0, 12'd0,    16'sh0002, 1'b0, 48'sd0},
      '{STEP_LOAD, CSR_ROWS,  3'd0, 12'd1,    16'sh0001, 1'b0, 48'sd0},
      '{STEP_RHS,  CSR_ROWS,  3'd0, 12'd0,    16'sh0001, 1'b0, 48'sd0},
      '{STEP_RHS,  CSR_ROWS,  3'd0, 12'd0,    16'shFFFF, 1'b1, -48'sd32769},
      // column count and depth of zero act as one
      '{STEP_CSR,  CSR_COLS,  3'd0, 12'd0,    16'sh0000, 1'b0, 48'sd0},
      '{STEP_CSR,  CSR_DEPTH, 3'd0, 12'd0,    16'sh0000, 1'b0, 48'sd0},
      '{STEP_RHS,  CSR_ROWS,  3'd0, 12'd0,    16'sh8000, 1'b1, 48'sd1073741824},
      '{STEP_LOAD, CSR_ROWS,  3'd0, 12'd0,    16'sh0000, 1'b0, 48'sd0},
      '{STEP_RHS,  CSR_ROWS,  3'd0, 12'd0,    16'sh7FFF, 1'b1, 48'sd0}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_BITS-1:0]      req_tdata = '0;       // row, depth_index, value, zero fill
   logic                     req_tuser = KIND_LOAD; // kind
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;            // out_row, out_column, sum, zero fill
   logic                     rsp_tlast;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_ROWS;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   small_m_matrix_multiply dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [VBITS-1:0]    lhs_words  [DEF_MAX_ROWS][DEF_MAX_DEPTH];
   bit                         lhs_loaded [DEF_MAX_ROWS][DEF_MAX_DEPTH];
   logic signed [ACC_BITS-1:0] row_sums   [DEF_MAX_ROWS] = '{default: '0};
   logic [DIDX_BITS-1:0]       depth_pos = '0;
   logic [COL_BITS-1:0]        col_pos = '0;
   logic [CFG_ROWS_BITS-1:0]   rows_reg = 1;
   logic [CFG_DEPTH_BITS-1:0]  depth_reg = 1;
   logic [CFG_COLS_BITS-1:0]   cols_reg = 1;
   int                         columns_done = 0;

   dot_type dot_products_due [$];
   int   errors = 0;
   int   burst_left = 0;
   bit   hold_armed = 1'b0;
   bit   hold_done = 1'b0;

   function automatic int active_rows();
      if (rows_reg == 0) return 1;
      return (rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_reg);
   endfunction

   function automatic int active_depth();
      if (depth_reg == 0) return 1;
      return (depth_reg > DEF_MAX_DEPTH) ? DEF_MAX_DEPTH : int'(depth_reg);
   endfunction

   function automatic int active_columns();
      return (cols_reg == 0) ? 1 : int'(cols_reg);
   endfunction

   // store a load beat or multiply-accumulate an rhs beat; a finished column queues one sum per row
   function automatic void accumulate_element(input element_type e);
      logic signed [ACC_BITS-1:0] product;
      dot_type                    dp;
      int                         rows;
      int                         next_col;
      rows = active_rows();
      if (e.kind == KIND_LOAD) begin
         lhs_words[e.row][e.didx]  = e.value;
         lhs_loaded[e.row][e.didx] = 1'b1;
         return;
      end
      for (int r = 0; r < rows; r++) begin
         product     = lhs_words[r][depth_pos] * $signed(e.value);
         row_sums[r] = row_sums[r] + product;
      end
      if (int'(depth_pos) + 1 < active_depth()) begin
         depth_pos = depth_pos + 1'b1;
         return;
      end
      for (int r = 0; r < rows; r++) begin
         dp.row  = ROW_BITS'(r);
         dp.col  = col_pos;
         dp.sum  = row_sums[r];
         dp.last = (r == rows - 1);
         dot_products_due.push_back(dp);
      end
      for (int r = 0; r < DEF_MAX_ROWS; r++) row_sums[r] = '0;
      depth_pos = '0;
      columns_done++;
      next_col = int'(col_pos) + 1;
      col_pos  = (next_col >= active_columns()) ? '0 : COL_BITS'(next_col);
   endfunction

   function automatic logic signed [VBITS-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return VBITS'($urandom);
      endcase
   endfunction

   // load any active row missing at the current depth first, so no unwritten entry is read
   function automatic element_type next_element();
      element_type e;
      int          d;
      d      = int'(depth_pos);
      e.row  = ROW_BITS'($urandom);
      e.didx = DIDX_BITS'($urandom);
      e.value = pick_value();
      for (int r = 0; r < active_rows(); r++) begin
         if (!lhs_loaded[r][d]) begin
            e.kind = KIND_LOAD;
            e.row  = ROW_BITS'(r);
            e.didx = DIDX_BITS'(d);
            return e;
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         e.kind = KIND_LOAD;
         if ($urandom_range(0, 7) != 0) e.didx = DIDX_BITS'($urandom_range(0, 15));
      end else begin
         e.kind = KIND_RHS;
      end
      return e;
   endfunction

   // sender: bursts of beats with random gaps between them
   task automatic push_item(input element_type e);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= e.kind;
      req_tdata  <= {{REQ_PAD{1'b0}}, e.value, e.didx, e.row};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      accumulate_element(e);
   endtask

   // stop offering, wait for every queued sum, then let the pipeline empty
   task automatic settle();
      int waited;
      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (dot_products_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (dot_products_due.size() != 0) begin
         $error("%0d dot products never arrived", dot_products_due.size());
         errors++;
         dot_products_due.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ROWS:  rows_reg  = data[CFG_ROWS_BITS-1:0];
         CSR_DEPTH: depth_reg = data[CFG_DEPTH_BITS-1:0];
         CSR_COLS:  cols_reg  = data[CFG_COLS_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: ready at a randomly redrawn rate, plus one long hold-off
   initial begin : result_sink
      int pct;
      int left;
      pct  = 100;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_done = 1'b1;
         end
         if (left == 0) begin
            case ($urandom_range(0, 2))
               0:       pct = 100;
               1:       pct = 70;
               default: pct = 25;
            endcase
            left = $urandom_range(16, 96);
         end
         left--;
         rsp_tready <= ($urandom_range(1, 100) <= pct);
      end
   end

   // compare each result beat against the oldest queued sum
   always @(posedge clock) begin : result_check
      dot_type got;
      dot_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.row  = rsp_tdata[ROW_BITS-1:0];
         got.col  = rsp_tdata[ROW_BITS +: COL_BITS];
         got.sum  = rsp_tdata[ROW_BITS + COL_BITS +: ACC_BITS];
         got.last = rsp_tlast;
         if (dot_products_due.size() == 0) begin
            $error("unexpected result beat: row %0d column %0d sum %0d",
                   got.row, got.col, got.sum);
            errors++;
         end else begin
            want = dot_products_due.pop_front();
            if (got.row != want.row) begin
               $error("out_row: expected %0d, got %0d", want.row, got.row);
               errors++;
            end
            if (got.col != want.col) begin
               $error("out_column: expected %0d, got %0d", want.col, got.col);
               errors++;
            end
            if (got.sum != want.sum) begin
               $error("sum: expected %0d, got %0d", want.sum, got.sum);
               errors++;
            end
            if (got.last != want.last) begin
               $error("last: expected %0d, got %0d", want.last, got.last);
               errors++;
            end
         end
      end
   end

   initial begin : stimulus
      step_type    s;
      element_type e;
      dot_type     fixed;
      int          rows_w;
      int          depth_w;
      int          cols_w;
      int          target;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed script
      for (int i = 0; i < SCRIPT_LEN; i++) begin
         s = SCRIPT[i];
         if (s.op == STEP_CSR) begin
            write_reg(s.idx, s.value);
         end else begin
            e.kind  = (s.op == STEP_RHS) ? KIND_RHS : KIND_LOAD;
            e.row   = s.row;
            e.didx  = s.didx;
            e.value = s.value;
            push_item(e);
            if (s.known) begin
               fixed     = dot_products_due.pop_back();
               fixed.sum = s.sum;
               dot_products_due.push_back(fixed);
            end
         end
      end

      // random phases; sizes change while a column may be half done
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin rows_w = 15; depth_w = 1; cols_w = 4;     end
            1: begin rows_w = 8;  depth_w = 3; cols_w = 65535; end
            2: begin rows_w = 0;  depth_w = 0; cols_w = 0;     end
            default: begin
               rows_w  = $urandom_range(0, 15);
               depth_w = $urandom_range(0, 9);
               cols_w  = $urandom_range(0, 6);
            end
         endcase
         write_reg(CSR_ROWS,  {12'($urandom), 4'(rows_w)});
         write_reg(CSR_DEPTH, {3'($urandom), 13'(depth_w)});
         write_reg(CSR_COLS,  16'(cols_w));
         if (phase == 0) hold_armed = 1'b1;
         repeat (PHASE_ITEMS) push_item(next_element());
      end

      // depth register above the maximum, then cut the column short with depth one
      write_reg(CSR_ROWS, 16'd1);
      write_reg(CSR_DEPTH, 16'h1FFF);
      repeat (DEEP_ITEMS) push_item(next_element());
      write_reg(CSR_DEPTH, 16'd1);
      target = columns_done + 1;
      while (columns_done < target) push_item(next_element());

      settle();
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
